@@ hdl/tsm_pkg.sv @@
`timescale 1ns / 1ps

package tsm_pkg;

    // Fixed field widths
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 32;
    localparam int CFG_DATA_W = 64;
    localparam int PLEN_W     = 4;
    localparam int CFG_IDX_W  = 2;

    // Defaults for the top-level parameters
    localparam int MAX_PATTERN_DEF = 8;
    localparam int CHUNK_BYTES_DEF = 511;

    // Special characters
    localparam logic [BYTE_W-1:0] SPACE_CHAR   = 8'h20;
    localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [BYTE_W-1:0] UPPER_A      = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_Z      = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES  = 2'd0,
        CFG_PATTERN_LENGTH = 2'd1
    } t_cfg_idx;

    // ASCII letters fold to lower case, everything else passes unchanged
    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b >= UPPER_A && b <= UPPER_Z) begin
            r = b + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

@@ hdl/token_substring_match_counter.sv @@
`timescale 1ns / 1ps
// The last byte's count goes to the result register, or to the skid stage on a stall.
// Throughput: one byte per cycle while not stalled; token/chunk state updates per byte.
// Input stalls only while both the result register and its skid stage hold counts.
// Reset (synchronous, active low): token, chunk and count state cleared, pattern
// registers cleared to zero, result buffer emptied.
module token_substring_match_counter #(
    parameter int MAX_PATTERN = tsm_pkg::MAX_PATTERN_DEF,
    parameter int CHUNK_BYTES = tsm_pkg::CHUNK_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [tsm_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                           i_last_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [tsm_pkg::COUNT_W-1:0]    o_match_count,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tsm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tsm_pkg::*;

    localparam int TOK_W = $clog2(MAX_PATTERN + 1);
    localparam int POS_W = $clog2(CHUNK_BYTES + 1);
    localparam int REC_W = BYTE_W * MAX_PATTERN;

    logic [CFG_DATA_W-1:0] r_pattern_bytes;
    logic [PLEN_W-1:0]     r_pattern_length;
    logic [REC_W-1:0]      r_recent;
    logic [TOK_W-1:0]      r_tok_len;
    logic                  r_tok_matched;
    logic [POS_W-1:0]      r_chunk_pos;
    logic [COUNT_W-1:0]    r_hit_count;

    logic [REC_W-1:0]   n_recent;
    logic [TOK_W-1:0]   n_tok_len;
    logic               n_tok_matched;
    logic [POS_W-1:0]   n_chunk_pos;
    logic [COUNT_W-1:0] n_hit_count;

    logic               accept;
    logic [TOK_W-1:0]   plen_eff;
    logic [REC_W-1:0]   shift_recent;
    logic [TOK_W-1:0]   len_inc;
    logic               tail_hit;
    logic               is_space;
    logic [TOK_W-1:0]   tok_len_a;
    logic               tok_m_a;
    logic [POS_W-1:0]   pos_inc;
    logic               chunk_end;
    logic               close_now;
    logic               tok_count;
    logic [COUNT_W-1:0] hit_next;
    logic               buf_full;

    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_bytes  <= '0;
            r_pattern_length <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PATTERN_BYTES:  r_pattern_bytes  <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Pattern length clamped to the compare window
    assign plen_eff = (r_pattern_length > PLEN_W'(MAX_PATTERN)) ?
                      TOK_W'(MAX_PATTERN) : TOK_W'(r_pattern_length);

    // Token window after taking this byte
    assign shift_recent = (r_recent << BYTE_W) | REC_W'(fold_case(i_data_byte));
    assign len_inc      = (r_tok_len < TOK_W'(MAX_PATTERN)) ? r_tok_len + 1'b1 : r_tok_len;

    tsm_matcher #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_matcher (
        .i_recent  (shift_recent),
        .i_tok_len (len_inc),
        .i_pattern (r_pattern_bytes[REC_W-1:0]),
        .i_plen    (plen_eff),
        .o_hit     (tail_hit)
    );

    // Token bookkeeping; a space closes the token without joining it
    assign is_space  = (i_data_byte == SPACE_CHAR);
    assign tok_len_a = is_space ? r_tok_len : len_inc;
    assign tok_m_a   = is_space ? r_tok_matched : (r_tok_matched || tail_hit);

    // Chunk boundary: newline or full line buffer
    assign pos_inc   = r_chunk_pos + 1'b1;
    assign chunk_end = (i_data_byte == NEWLINE_CHAR) || (pos_inc >= POS_W'(CHUNK_BYTES));

    // At most one token closes per byte; count saturates
    assign close_now = is_space || chunk_end || i_last_byte;
    assign tok_count = close_now && (tok_len_a != '0) && tok_m_a;
    assign hit_next  = (tok_count && (r_hit_count != '1)) ? r_hit_count + 1'b1 : r_hit_count;

    // Next state
    always_comb begin
        n_recent      = r_recent;
        n_tok_len     = r_tok_len;
        n_tok_matched = r_tok_matched;
        n_chunk_pos   = r_chunk_pos;
        n_hit_count   = r_hit_count;
        if (accept) begin
            if (i_last_byte) begin
                n_recent      = '0;
                n_tok_len     = '0;
                n_tok_matched = 1'b0;
                n_chunk_pos   = '0;
                n_hit_count   = '0;
            end else begin
                n_recent      = close_now ? '0 : shift_recent;
                n_tok_len     = close_now ? '0 : len_inc;
                n_tok_matched = close_now ? 1'b0 : tok_m_a;
                n_chunk_pos   = chunk_end ? '0 : pos_inc;
                n_hit_count   = hit_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent      <= '0;
            r_tok_len     <= '0;
            r_tok_matched <= 1'b0;
            r_chunk_pos   <= '0;
            r_hit_count   <= '0;
        end else begin
            r_recent      <= n_recent;
            r_tok_len     <= n_tok_len;
            r_tok_matched <= n_tok_matched;
            r_chunk_pos   <= n_chunk_pos;
            r_hit_count   <= n_hit_count;
        end
    end

    // Result register with skid stage
    tsm_result_buf u_result_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (accept && i_last_byte),
        .i_push_count (hit_next),
        .o_full       (buf_full),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_count      (o_match_count)
    );

    assign o_stall = buf_full;

    // Checks
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_byte) |=> (r_hit_count == '0 && r_tok_len == '0 &&
                                     r_chunk_pos == '0 && !r_tok_matched))
        else $error("state not cleared after last byte");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_byte) |=> o_valid)
        else $error("no result after last byte");

    a_chunk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chunk_pos < POS_W'(CHUNK_BYTES))
        else $error("chunk position out of range");

    a_tok_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok_len <= TOK_W'(MAX_PATTERN))
        else $error("token length above window");

endmodule

@@ hdl/tsm_matcher.sv @@
`timescale 1ns / 1ps

module tsm_matcher #(
    parameter int MAX_PATTERN = tsm_pkg::MAX_PATTERN_DEF
) (
    input  logic [tsm_pkg::BYTE_W*MAX_PATTERN-1:0] i_recent,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]       i_tok_len,
    input  logic [tsm_pkg::BYTE_W*MAX_PATTERN-1:0] i_pattern,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]       i_plen,
    output logic                                   o_hit
);
    import tsm_pkg::*;

    localparam int TOK_W = $clog2(MAX_PATTERN + 1);

    logic [MAX_PATTERN-1:0] len_hit;
    logic                   sel_hit;

    // One compare row per possible pattern length; the newest byte lines up
    // with the last pattern character.
    always_comb begin
        for (int l = 0; l < MAX_PATTERN; l++) begin
            len_hit[l] = 1'b1;
            for (int k = 0; k <= l; k++) begin
                if (i_recent[BYTE_W*k +: BYTE_W] !=
                    fold_case(i_pattern[BYTE_W*(l-k) +: BYTE_W])) begin
                    len_hit[l] = 1'b0;
                end
            end
        end
    end

    // Pick the row for the active length
    always_comb begin
        sel_hit = 1'b0;
        for (int l = 0; l < MAX_PATTERN; l++) begin
            if (i_plen == TOK_W'(l + 1)) begin
                sel_hit = len_hit[l];
            end
        end
    end

    // Empty pattern matches any token; otherwise the token must be long enough
    assign o_hit = (i_plen == '0) || ((i_tok_len >= i_plen) && sel_hit);

endmodule

@@ hdl/tsm_result_buf.sv @@
`timescale 1ns / 1ps

module tsm_result_buf (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [tsm_pkg::COUNT_W-1:0] i_push_count,
    output logic                        o_full,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [tsm_pkg::COUNT_W-1:0] o_count
);
    import tsm_pkg::*;

    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_skid_valid;
    logic [COUNT_W-1:0] r_skid_count;

    // Control: output register drains first, skid catches a push while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_count <= r_skid_count;
            end else if (i_push) begin
                r_out_count <= i_push_count;
            end
        end else if (i_push) begin
            r_skid_count <= i_push_count;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_count = r_out_count;

endmodule
